// ----- design/dds_pkg.sv -----
// Door drive sequencer package: the payload structs, the sequencer state and
// configuration types, the state, drive and command codes, and the reset values.
// It depends on nothing; every design file uses it through scoped names.
`default_nettype none

package dds_pkg;

	localparam int unsigned TIMER_CAP_DEFAULT = 252;
	localparam int unsigned NUM_REGS          = 8;
	localparam int unsigned REG_INDEX_W       = 3;
	localparam int unsigned REG_DATA_W        = 8;

	// Drive codes for the main and the auxiliary motor.
	localparam logic [1:0] DRV_STOP  = 2'd0;
	localparam logic [1:0] DRV_OPEN  = 2'd1;
	localparam logic [1:0] DRV_CLOSE = 2'd2;

	// Serial command codes.
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_OPEN  = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	// Sequencer states.
	localparam logic [3:0] ST_STOP         = 4'd0;
	localparam logic [3:0] ST_OPEN         = 4'd1;
	localparam logic [3:0] ST_CLOSED       = 4'd2;
	localparam logic [3:0] ST_OPEN_RELEASE = 4'd3;
	localparam logic [3:0] ST_OPEN_WAIT    = 4'd4;
	localparam logic [3:0] ST_OPEN_START   = 4'd5;
	localparam logic [3:0] ST_OPEN_PAUSE   = 4'd6;
	localparam logic [3:0] ST_OPEN_RUN     = 4'd7;
	localparam logic [3:0] ST_OPEN_BRAKE   = 4'd8;
	localparam logic [3:0] ST_CLOSE_AUX    = 4'd9;
	localparam logic [3:0] ST_CLOSE_MED    = 4'd10;
	localparam logic [3:0] ST_CLOSE_MAX    = 4'd11;
	localparam logic [3:0] ST_CLOSE_COAST  = 4'd12;
	localparam logic [3:0] ST_CLOSE_SLOW   = 4'd13;
	localparam logic [3:0] ST_CLOSE_HOLD   = 4'd14;
	localparam logic [3:0] ST_CLOSE_REOPEN = 4'd15;

	// Configuration register indexes.
	localparam logic [REG_INDEX_W-1:0] REG_MAGNET_RELEASE_WAIT = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_OPENING_PAUSE_WAIT  = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_CLOSING_COAST_WAIT  = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_LATCH_HOLD_WAIT     = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_MAIN_SPEED_MEDIUM   = 3'd4;
	localparam logic [REG_INDEX_W-1:0] REG_MAIN_SPEED_MAX      = 3'd5;
	localparam logic [REG_INDEX_W-1:0] REG_MAIN_SPEED_MIN      = 3'd6;
	localparam logic [REG_INDEX_W-1:0] REG_MAIN_SPEED_BRAKE    = 3'd7;

	typedef struct packed {
		logic       tick;
		logic       fully_open;
		logic       fully_closed;
		logic       nearly_open;
		logic       nearly_closed;
		logic       obstacle_near;
		logic       aux_inner_limit;
		logic       aux_outer_limit;
		logic       toggle_button;
		logic       halt_button;
		logic [1:0] command;
	} sample_t;

	typedef struct packed {
		logic [1:0] main_drive;
		logic [7:0] main_duty;
		logic [1:0] aux_drive;
		logic       magnet_engaged;
		logic [3:0] state_code;
	} result_t;

	typedef struct packed {
		logic [7:0] magnet_release_wait;
		logic [7:0] opening_pause_wait;
		logic [7:0] closing_coast_wait;
		logic [7:0] latch_hold_wait;
		logic [7:0] main_speed_medium;
		logic [7:0] main_speed_max;
		logic [7:0] main_speed_min;
		logic [7:0] main_speed_brake;
	} cfg_t;

	typedef struct packed {
		logic [3:0] door_state;
		logic [7:0] wait_timer;
		logic [1:0] main_drive;
		logic [7:0] main_duty;
		logic [1:0] aux_drive;
		logic       magnet;
		logic       started;
	} ctx_t;

	localparam cfg_t CFG_RESET = '{
		magnet_release_wait: 8'd10,
		opening_pause_wait:  8'd50,
		closing_coast_wait:  8'd15,
		latch_hold_wait:     8'd75,
		main_speed_medium:   8'd150,
		main_speed_max:      8'd254,
		main_speed_min:      8'd80,
		main_speed_brake:    8'd100
	};

	localparam ctx_t CTX_RESET = '{
		door_state: ST_STOP,
		wait_timer: 8'd0,
		main_drive: DRV_STOP,
		main_duty:  8'd0,
		aux_drive:  DRV_STOP,
		magnet:     1'b0,
		started:    1'b0
	};

endpackage

`default_nettype wire

// ----- design/dds_cfg.sv -----
// Configuration register file of the door drive sequencer: eight 8-bit
// registers written through a plain index/data port. Uses dds_pkg.
`default_nettype none

module dds_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [dds_pkg::REG_INDEX_W-1:0]     cfg_index,
	input  wire logic [dds_pkg::REG_DATA_W-1:0]      cfg_data,
	output dds_pkg::cfg_t                            cfg
);

	dds_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= dds_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dds_pkg::REG_MAGNET_RELEASE_WAIT: cfg_q.magnet_release_wait <= cfg_data;
				dds_pkg::REG_OPENING_PAUSE_WAIT:  cfg_q.opening_pause_wait  <= cfg_data;
				dds_pkg::REG_CLOSING_COAST_WAIT:  cfg_q.closing_coast_wait  <= cfg_data;
				dds_pkg::REG_LATCH_HOLD_WAIT:     cfg_q.latch_hold_wait     <= cfg_data;
				dds_pkg::REG_MAIN_SPEED_MEDIUM:   cfg_q.main_speed_medium   <= cfg_data;
				dds_pkg::REG_MAIN_SPEED_MAX:      cfg_q.main_speed_max      <= cfg_data;
				dds_pkg::REG_MAIN_SPEED_MIN:      cfg_q.main_speed_min      <= cfg_data;
				dds_pkg::REG_MAIN_SPEED_BRAKE:    cfg_q.main_speed_brake    <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/dds_step.sv -----
// Next-state logic of the door drive sequencer: one sample plus the held
// state give the following state and the result. Uses dds_pkg.
`default_nettype none

module dds_step #(
	parameter int unsigned TIMER_CAP = dds_pkg::TIMER_CAP_DEFAULT
) (
	input  wire dds_pkg::sample_t sample,
	input  wire dds_pkg::ctx_t    ctx,
	input  wire dds_pkg::cfg_t    cfg,
	output dds_pkg::ctx_t         ctx_next,
	output dds_pkg::result_t      result
);

	localparam logic [7:0] CAP = 8'(TIMER_CAP);

	logic [3:0]    cur_state;
	logic [3:0]    s;
	logic          clr;
	dds_pkg::ctx_t nxt;

	always_comb begin
		nxt         = ctx;
		nxt.started = 1'b1;
		clr         = 1'b0;

		// The very first sample places the door from its limit sensors.
		cur_state = ctx.door_state;
		if (!ctx.started) begin
			if (sample.fully_closed) begin
				cur_state = dds_pkg::ST_CLOSED;
			end else if (sample.fully_open) begin
				cur_state = dds_pkg::ST_OPEN;
			end
		end
		s = cur_state;

		unique case (cur_state)
			dds_pkg::ST_STOP: begin
				nxt.main_drive = dds_pkg::DRV_STOP;
				nxt.main_duty  = 8'd0;
				nxt.aux_drive  = dds_pkg::DRV_STOP;
				if (sample.toggle_button) begin
					if (sample.fully_open)   s = dds_pkg::ST_CLOSE_AUX;
					if (sample.fully_closed) s = dds_pkg::ST_OPEN_RELEASE;
				end
			end
			dds_pkg::ST_OPEN: begin
				if (sample.toggle_button) s = dds_pkg::ST_CLOSE_AUX;
				nxt.main_drive = dds_pkg::DRV_STOP;
				nxt.main_duty  = 8'd0;
				nxt.aux_drive  = dds_pkg::DRV_STOP;
				nxt.magnet     = 1'b0;
			end
			dds_pkg::ST_CLOSED: begin
				if (sample.toggle_button) s = dds_pkg::ST_OPEN_RELEASE;
				nxt.main_drive = dds_pkg::DRV_STOP;
				nxt.main_duty  = 8'd0;
				nxt.aux_drive  = dds_pkg::DRV_STOP;
				nxt.magnet     = 1'b1;
			end
			dds_pkg::ST_OPEN_RELEASE: begin
				nxt.magnet = 1'b0;
				clr        = 1'b1;
				s          = dds_pkg::ST_OPEN_WAIT;
			end
			dds_pkg::ST_OPEN_WAIT: begin
				if (ctx.wait_timer > cfg.magnet_release_wait) s = dds_pkg::ST_OPEN_START;
			end
			dds_pkg::ST_OPEN_START: begin
				nxt.aux_drive  = dds_pkg::DRV_OPEN;
				nxt.main_drive = dds_pkg::DRV_OPEN;
				nxt.main_duty  = cfg.main_speed_medium;
				if (sample.nearly_closed) begin
					s   = dds_pkg::ST_OPEN_PAUSE;
					clr = 1'b1;
				end
			end
			dds_pkg::ST_OPEN_PAUSE: begin
				if (ctx.wait_timer > cfg.opening_pause_wait) begin
					s = dds_pkg::ST_OPEN_RUN;
				end else begin
					nxt.aux_drive  = dds_pkg::DRV_STOP;
					nxt.main_drive = dds_pkg::DRV_OPEN;
					nxt.main_duty  = cfg.main_speed_medium;
				end
			end
			dds_pkg::ST_OPEN_RUN: begin
				nxt.aux_drive = sample.aux_inner_limit ? dds_pkg::DRV_STOP : dds_pkg::DRV_OPEN;
				if (sample.nearly_open) begin
					nxt.main_drive = dds_pkg::DRV_OPEN;
					nxt.main_duty  = cfg.main_speed_brake;
					s              = dds_pkg::ST_OPEN_BRAKE;
				end else if (sample.fully_open) begin
					nxt.main_drive = dds_pkg::DRV_STOP;
					nxt.main_duty  = 8'd0;
					s              = dds_pkg::ST_OPEN_BRAKE;
				end else begin
					nxt.main_drive = dds_pkg::DRV_OPEN;
					nxt.main_duty  = sample.aux_inner_limit ? cfg.main_speed_max
					                                        : cfg.main_speed_medium;
				end
			end
			dds_pkg::ST_OPEN_BRAKE: begin
				nxt.aux_drive = sample.aux_inner_limit ? dds_pkg::DRV_STOP : dds_pkg::DRV_OPEN;
				if (sample.fully_open) begin
					nxt.main_drive = dds_pkg::DRV_STOP;
					nxt.main_duty  = 8'd0;
				end else begin
					nxt.main_drive = dds_pkg::DRV_OPEN;
					nxt.main_duty  = cfg.main_speed_brake;
				end
				if (sample.aux_inner_limit && sample.fully_open) s = dds_pkg::ST_OPEN;
			end
			dds_pkg::ST_CLOSE_AUX: begin
				if (sample.aux_inner_limit) begin
					nxt.aux_drive = dds_pkg::DRV_STOP;
					s             = dds_pkg::ST_CLOSE_MED;
				end else begin
					nxt.aux_drive = dds_pkg::DRV_CLOSE;
				end
			end
			dds_pkg::ST_CLOSE_MED: begin
				if (sample.obstacle_near) begin
					nxt.main_drive = dds_pkg::DRV_STOP;
					nxt.main_duty  = 8'd0;
				end else if (!sample.nearly_open) begin
					nxt.main_drive = dds_pkg::DRV_CLOSE;
					nxt.main_duty  = cfg.main_speed_medium;
				end else begin
					nxt.main_drive = dds_pkg::DRV_CLOSE;
					nxt.main_duty  = cfg.main_speed_max;
					s              = dds_pkg::ST_CLOSE_MAX;
				end
				if (sample.nearly_closed) begin
					clr = 1'b1;
					s   = dds_pkg::ST_CLOSE_COAST;
				end
				if (sample.fully_closed) s = dds_pkg::ST_CLOSE_REOPEN;
			end
			dds_pkg::ST_CLOSE_MAX: begin
				if (sample.obstacle_near) begin
					nxt.main_drive = dds_pkg::DRV_STOP;
					nxt.main_duty  = 8'd0;
				end else if (sample.nearly_closed) begin
					clr = 1'b1;
					s   = dds_pkg::ST_CLOSE_COAST;
				end else begin
					nxt.main_drive = dds_pkg::DRV_CLOSE;
					nxt.main_duty  = cfg.main_speed_max;
				end
			end
			dds_pkg::ST_CLOSE_COAST: begin
				if (ctx.wait_timer > cfg.closing_coast_wait) begin
					s = dds_pkg::ST_CLOSE_SLOW;
				end else begin
					nxt.main_drive = dds_pkg::DRV_CLOSE;
					nxt.main_duty  = cfg.main_speed_max;
				end
			end
			dds_pkg::ST_CLOSE_SLOW: begin
				if (sample.obstacle_near) begin
					nxt.main_drive = dds_pkg::DRV_STOP;
					nxt.main_duty  = 8'd0;
					nxt.aux_drive  = dds_pkg::DRV_STOP;
				end else if (sample.fully_closed) begin
					nxt.magnet = 1'b1;
					clr        = 1'b1;
					s          = dds_pkg::ST_CLOSE_HOLD;
				end else begin
					nxt.aux_drive  = dds_pkg::DRV_CLOSE;
					nxt.main_drive = dds_pkg::DRV_CLOSE;
					nxt.main_duty  = cfg.main_speed_min;
				end
			end
			dds_pkg::ST_CLOSE_HOLD: begin
				if (ctx.wait_timer > cfg.latch_hold_wait) begin
					nxt.main_drive = dds_pkg::DRV_STOP;
					nxt.main_duty  = 8'd0;
					s              = dds_pkg::ST_CLOSE_REOPEN;
				end
			end
			dds_pkg::ST_CLOSE_REOPEN: begin
				if (sample.aux_outer_limit) begin
					nxt.aux_drive = dds_pkg::DRV_STOP;
					s             = dds_pkg::ST_CLOSED;
				end else begin
					nxt.aux_drive = dds_pkg::DRV_OPEN;
				end
			end
		endcase

		// Serial command, then the halt button, override the state logic.
		unique case (sample.command)
			dds_pkg::CMD_NONE: begin
			end
			dds_pkg::CMD_OPEN: begin
				if ((s == dds_pkg::ST_CLOSED || s == dds_pkg::ST_STOP) && sample.fully_closed)
					s = dds_pkg::ST_OPEN_RELEASE;
			end
			dds_pkg::CMD_CLOSE: begin
				if ((s == dds_pkg::ST_OPEN || s == dds_pkg::ST_STOP) && sample.fully_open)
					s = dds_pkg::ST_CLOSE_AUX;
			end
			dds_pkg::CMD_STOP: begin
				s = dds_pkg::ST_STOP;
			end
		endcase
		if (sample.halt_button) s = dds_pkg::ST_STOP;

		nxt.door_state = s;

		// A clear wins over the tick of the same step; counting stops at the cap.
		if (clr) begin
			nxt.wait_timer = 8'd0;
		end else if (sample.tick) begin
			nxt.wait_timer = (ctx.wait_timer >= CAP) ? CAP : ctx.wait_timer + 8'd1;
		end
	end

	assign ctx_next = nxt;

	assign result.main_drive     = nxt.main_drive;
	assign result.main_duty      = nxt.main_duty;
	assign result.aux_drive      = nxt.aux_drive;
	assign result.magnet_engaged = nxt.magnet;
	assign result.state_code     = nxt.door_state;

endmodule

`default_nettype wire

// ----- design/door_drive_sequencer.sv -----
// Top level of the door drive sequencer: input register, step logic, result
// register, held sequencer state and the configuration registers. Uses dds_pkg.
//
// Usage: each transfer on the sample channel (sample_valid/sample_ready) carries
// one sample of the door limit and position sensors, the proximity sensor, the
// qualified buttons, a serial command and a 100 ms tick flag. For every sample
// the block returns exactly one transfer on the result channel
// (result_valid/result_ready): the held main motor drive and duty, the aux motor
// drive, the magnet command and the sequencer state after the step.
// A sample taken into the input register passes through the step logic into the
// result register, from which the receiver takes it on the result port.
// Throughput is one sample per cycle while the receiver does not stall;
// the step logic between the input register and the result register is a single
// pass of comparisons and selects, and the sequencer state is updated at the
// same edge at which the result is loaded, so the next sample sees it at once.
// When the receiver stalls, the result register holds its transfer, one more
// sample waits in the input register, and sample_ready then drops until the
// result is taken. Nothing is lost or repeated.
// Reset (arst_n low) puts the sequencer in the stop state with motors and magnet
// off, the wait timer at zero, the registers at their defaults, and marks the
// next sample as the first, whose limit sensors place the door open or closed.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the next
// edge and are meant to be made while no sample is in flight.
`default_nettype none

module door_drive_sequencer #(
	parameter int unsigned TIMER_CAP = dds_pkg::TIMER_CAP_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire dds_pkg::sample_t                sample,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output dds_pkg::result_t                     result,
	input  wire logic                            cfg_wr_en,
	input  wire logic [dds_pkg::REG_INDEX_W-1:0] cfg_index,
	input  wire logic [dds_pkg::REG_DATA_W-1:0]  cfg_data
);

	logic             valid_s1;
	dds_pkg::sample_t sample_s1;
	logic             result_valid_q;
	dds_pkg::result_t result_q;
	dds_pkg::ctx_t    ctx_q;
	dds_pkg::ctx_t    ctx_next;
	dds_pkg::result_t step_result;
	dds_pkg::cfg_t    cfg;
	logic             advance;

	dds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dds_step #(
		.TIMER_CAP (TIMER_CAP)
	) u_step (
		.sample   (sample_s1),
		.ctx      (ctx_q),
		.cfg      (cfg),
		.ctx_next (ctx_next),
		.result   (step_result)
	);

	// The registered sample moves on whenever the result register is free or
	// is being emptied in this cycle.
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_s1 <= '0;
		end else if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			ctx_q          <= dds_pkg::CTX_RESET;
		end else if (advance) begin
			result_valid_q <= 1'b1;
			ctx_q          <= ctx_next;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The wait timer saturates at the cap.
	a_timer_capped: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.wait_timer <= 8'(TIMER_CAP))
		else $error("wait timer above its cap");

	// A stopped main motor always reports zero duty.
	a_duty_zero_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.main_drive != dds_pkg::DRV_STOP || result_q.main_duty == 8'd0))
		else $error("nonzero duty with main motor stopped");

	// Once a sample has gone through, the first-sample placement is done.
	a_started_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ctx_q.started)
		else $error("sequencer not marked started after a step");

	// Input back-pressure only comes from a stalled, full result register.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && result_valid_q && !result_ready))
		else $error("sample channel stalled without cause");

	// A stalled result stays in place and the state does not move under it.
	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ctx_q))
		else $error("sequencer state changed without a step");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the door drive sequencer: a directed walk through
// power-up, serial commands and the closing path, then guided random door cycles
// under several register settings. Depends on dds_pkg and door_drive_sequencer.

module testbench;
	import dds_pkg::*;

	localparam int unsigned CLK_PERIOD     = 20;
	localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
	localparam logic [7:0]  WAIT_CAP       = 8'(TIMER_CAP_DEFAULT);

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_ready;
	sample_t                sample       = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_wr_en    = 1'b0;
	logic [REG_INDEX_W-1:0] cfg_index    = '0;
	logic [REG_DATA_W-1:0]  cfg_data     = '0;

	door_drive_sequencer #(
		.TIMER_CAP(TIMER_CAP_DEFAULT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Our own copy of the sequencer: state, wait timer, held motor and magnet
	// commands, the first-sample flag and the register file. It advances once
	// for every sample transfer, in acceptance order.
	logic [3:0] door_state      = ST_STOP;
	logic [7:0] door_timer      = 8'd0;
	logic [1:0] door_main_drive = DRV_STOP;
	logic [7:0] door_main_duty  = 8'd0;
	logic [1:0] door_aux_drive  = DRV_STOP;
	logic       door_magnet     = 1'b0;
	logic       door_started    = 1'b0;
	cfg_t       door_cfg        = CFG_RESET;

	// Outputs predicted for accepted samples, oldest first.
	result_t door_outputs_due[$];

	// Pacing controls: the tests switch idling off for some stretches.
	bit          sender_gaps     = 1'b1;
	bit          receiver_stalls = 1'b1;
	int unsigned ready_hold      = 0;

	int unsigned failures        = 0;
	int unsigned samples_sent    = 0;
	int unsigned results_checked = 0;
	int unsigned settings_used   = 1;
	logic [15:0] states_seen     = '0;

	function automatic bit chance(input int unsigned n);
		return $urandom_range(0, n - 1) == 0;
	endfunction

	// Motor commands are held: a stop drive always carries a zero duty.
	function automatic void drive_main(input logic [1:0] drive, input logic [7:0] duty);
		door_main_drive = drive;
		door_main_duty  = (drive == DRV_STOP) ? 8'd0 : duty;
	endfunction

	// One step of the sequencer. The state logic sees the timer as it was
	// before the step; the serial command and then the halt button are applied
	// on top of whatever the state logic chose.
	function automatic result_t advance_door(input sample_t s);
		logic [3:0] next;
		logic [7:0] held;
		logic       clear;
		result_t    r;
		held  = door_timer;
		clear = 1'b0;
		// The very first sample places the door by its limit sensors, and the
		// closed sensor wins when both are active.
		if (!door_started) begin
			door_started = 1'b1;
			if (s.fully_closed)
				door_state = ST_CLOSED;
			else if (s.fully_open)
				door_state = ST_OPEN;
		end
		next = door_state;
		case (door_state)
			ST_STOP: begin
				drive_main(DRV_STOP, 8'd0);
				door_aux_drive = DRV_STOP;
				if (s.toggle_button) begin
					if (s.fully_open)
						next = ST_CLOSE_AUX;
					if (s.fully_closed)
						next = ST_OPEN_RELEASE;
				end
			end
			ST_OPEN: begin
				if (s.toggle_button)
					next = ST_CLOSE_AUX;
				drive_main(DRV_STOP, 8'd0);
				door_aux_drive = DRV_STOP;
				door_magnet    = 1'b0;
			end
			ST_CLOSED: begin
				if (s.toggle_button)
					next = ST_OPEN_RELEASE;
				drive_main(DRV_STOP, 8'd0);
				door_aux_drive = DRV_STOP;
				door_magnet    = 1'b1;
			end
			ST_OPEN_RELEASE: begin
				door_magnet = 1'b0;
				clear       = 1'b1;
				next        = ST_OPEN_WAIT;
			end
			ST_OPEN_WAIT: begin
				if (held > door_cfg.magnet_release_wait)
					next = ST_OPEN_START;
			end
			ST_OPEN_START: begin
				door_aux_drive = DRV_OPEN;
				drive_main(DRV_OPEN, door_cfg.main_speed_medium);
				if (s.nearly_closed) begin
					next  = ST_OPEN_PAUSE;
					clear = 1'b1;
				end
			end
			ST_OPEN_PAUSE: begin
				if (held > door_cfg.opening_pause_wait) begin
					next = ST_OPEN_RUN;
				end else begin
					door_aux_drive = DRV_STOP;
					drive_main(DRV_OPEN, door_cfg.main_speed_medium);
				end
			end
			ST_OPEN_RUN: begin
				door_aux_drive = s.aux_inner_limit ? DRV_STOP : DRV_OPEN;
				if (s.nearly_open) begin
					drive_main(DRV_OPEN, door_cfg.main_speed_brake);
					next = ST_OPEN_BRAKE;
				end else if (s.fully_open) begin
					drive_main(DRV_STOP, 8'd0);
					next = ST_OPEN_BRAKE;
				end else begin
					drive_main(DRV_OPEN, s.aux_inner_limit ? door_cfg.main_speed_max
						: door_cfg.main_speed_medium);
				end
			end
			ST_OPEN_BRAKE: begin
				door_aux_drive = s.aux_inner_limit ? DRV_STOP : DRV_OPEN;
				if (s.fully_open)
					drive_main(DRV_STOP, 8'd0);
				else
					drive_main(DRV_OPEN, door_cfg.main_speed_brake);
				if (s.aux_inner_limit && s.fully_open)
					next = ST_OPEN;
			end
			ST_CLOSE_AUX: begin
				if (s.aux_inner_limit) begin
					door_aux_drive = DRV_STOP;
					next           = ST_CLOSE_MED;
				end else begin
					door_aux_drive = DRV_CLOSE;
				end
			end
			ST_CLOSE_MED: begin
				// An obstacle pauses the main motor without leaving the state.
				if (s.obstacle_near) begin
					drive_main(DRV_STOP, 8'd0);
				end else if (!s.nearly_open) begin
					drive_main(DRV_CLOSE, door_cfg.main_speed_medium);
				end else begin
					drive_main(DRV_CLOSE, door_cfg.main_speed_max);
					next = ST_CLOSE_MAX;
				end
				if (s.nearly_closed) begin
					clear = 1'b1;
					next  = ST_CLOSE_COAST;
				end
				if (s.fully_closed)
					next = ST_CLOSE_REOPEN;
			end
			ST_CLOSE_MAX: begin
				if (s.obstacle_near) begin
					drive_main(DRV_STOP, 8'd0);
				end else if (s.nearly_closed) begin
					clear = 1'b1;
					next  = ST_CLOSE_COAST;
				end else begin
					drive_main(DRV_CLOSE, door_cfg.main_speed_max);
				end
			end
			ST_CLOSE_COAST: begin
				if (held > door_cfg.closing_coast_wait)
					next = ST_CLOSE_SLOW;
				else
					drive_main(DRV_CLOSE, door_cfg.main_speed_max);
			end
			ST_CLOSE_SLOW: begin
				// Here an obstacle stops the aux motor as well.
				if (s.obstacle_near) begin
					drive_main(DRV_STOP, 8'd0);
					door_aux_drive = DRV_STOP;
				end else if (s.fully_closed) begin
					door_magnet = 1'b1;
					clear       = 1'b1;
					next        = ST_CLOSE_HOLD;
				end else begin
					door_aux_drive = DRV_CLOSE;
					drive_main(DRV_CLOSE, door_cfg.main_speed_min);
				end
			end
			ST_CLOSE_HOLD: begin
				if (held > door_cfg.latch_hold_wait) begin
					drive_main(DRV_STOP, 8'd0);
					next = ST_CLOSE_REOPEN;
				end
			end
			default: begin
				if (s.aux_outer_limit) begin
					door_aux_drive = DRV_STOP;
					next           = ST_CLOSED;
				end else begin
					door_aux_drive = DRV_OPEN;
				end
			end
		endcase
		case (s.command)
			CMD_OPEN: begin
				if ((next == ST_CLOSED || next == ST_STOP) && s.fully_closed)
					next = ST_OPEN_RELEASE;
			end
			CMD_CLOSE: begin
				if ((next == ST_OPEN || next == ST_STOP) && s.fully_open)
					next = ST_CLOSE_AUX;
			end
			CMD_STOP: next = ST_STOP;
			default: ;
		endcase
		if (s.halt_button)
			next = ST_STOP;
		door_state = next;
		// A clear wins over the tick of the same step; the count saturates.
		if (clear)
			door_timer = 8'd0;
		else if (s.tick)
			door_timer = (held >= WAIT_CAP) ? WAIT_CAP : held + 8'd1;
		r.main_drive     = door_main_drive;
		r.main_duty      = door_main_duty;
		r.aux_drive      = door_aux_drive;
		r.magnet_engaged = door_magnet;
		r.state_code     = door_state;
		return r;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("state %0d main %0d duty %0d aux %0d magnet %0d",
			r.state_code, r.main_drive, r.main_duty, r.aux_drive, r.magnet_engaged);
	endfunction

	function automatic void record_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("ERROR at %0t: %s", $realtime, what);
	endfunction

	// Mostly short sender gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!sender_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Sends one sample and, at the edge where the transfer happens, predicts
	// the outputs it must produce. Valid is only lowered when a gap follows,
	// so back-to-back transfers keep it high.
	task automatic send_sample(input sample_t s);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (!sample_ready);
		door_outputs_due.push_back(advance_door(s));
		samples_sent++;
	endtask

	// Stops sending and holds off until every predicted output has come back.
	task automatic wait_for_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (door_outputs_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [REG_INDEX_W-1:0] index,
		input logic [REG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		case (index)
			REG_MAGNET_RELEASE_WAIT: door_cfg.magnet_release_wait = value;
			REG_OPENING_PAUSE_WAIT:  door_cfg.opening_pause_wait  = value;
			REG_CLOSING_COAST_WAIT:  door_cfg.closing_coast_wait  = value;
			REG_LATCH_HOLD_WAIT:     door_cfg.latch_hold_wait     = value;
			REG_MAIN_SPEED_MEDIUM:   door_cfg.main_speed_medium   = value;
			REG_MAIN_SPEED_MAX:      door_cfg.main_speed_max      = value;
			REG_MAIN_SPEED_MIN:      door_cfg.main_speed_min      = value;
			default:                 door_cfg.main_speed_brake    = value;
		endcase
	endtask

	// Drains the block, then writes all eight registers on consecutive cycles.
	task automatic program_registers(input cfg_t c);
		wait_for_results();
		write_register(REG_MAGNET_RELEASE_WAIT, c.magnet_release_wait);
		write_register(REG_OPENING_PAUSE_WAIT, c.opening_pause_wait);
		write_register(REG_CLOSING_COAST_WAIT, c.closing_coast_wait);
		write_register(REG_LATCH_HOLD_WAIT, c.latch_hold_wait);
		write_register(REG_MAIN_SPEED_MEDIUM, c.main_speed_medium);
		write_register(REG_MAIN_SPEED_MAX, c.main_speed_max);
		write_register(REG_MAIN_SPEED_MIN, c.main_speed_min);
		write_register(REG_MAIN_SPEED_BRAKE, c.main_speed_brake);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Fields in struct order: tick, fully_open, fully_closed, nearly_open,
	// nearly_closed, obstacle_near, aux_inner_limit, aux_outer_limit,
	// toggle_button, halt_button, command.
	function automatic sample_t make_sample(input bit tk, fo, fc, no, nc, ob, ai, ao,
		tg, hb, input logic [1:0] cmd);
		sample_t s;
		s = '{tk, fo, fc, no, nc, ob, ai, ao, tg, hb, cmd};
		return s;
	endfunction

	// A sample that is likely to move the sequencer on from the state it is in
	// now, with the sensors that state waits for set at random.
	function automatic sample_t guided_sample();
		sample_t s;
		s      = '0;
		s.tick = !chance(4);
		case (door_state)
			ST_STOP: begin
				s.fully_open    = chance(2);
				s.fully_closed  = chance(3);
				s.toggle_button = chance(2);
			end
			ST_OPEN: begin
				s.fully_open    = 1'b1;
				s.toggle_button = chance(15);
			end
			ST_CLOSED: begin
				s.fully_closed  = 1'b1;
				s.toggle_button = chance(15);
			end
			ST_OPEN_START: s.nearly_closed = chance(4);
			ST_OPEN_RUN: begin
				s.aux_inner_limit = chance(2);
				s.nearly_open     = chance(5);
				s.fully_open      = chance(8);
			end
			ST_OPEN_BRAKE: begin
				s.aux_inner_limit = chance(2);
				s.fully_open      = chance(2);
			end
			ST_CLOSE_AUX: s.aux_inner_limit = chance(3);
			ST_CLOSE_MED: begin
				s.obstacle_near = chance(8);
				s.nearly_open   = chance(3);
				s.nearly_closed = chance(6);
				s.fully_closed  = chance(12);
			end
			ST_CLOSE_MAX: begin
				s.obstacle_near = chance(8);
				s.nearly_closed = chance(5);
			end
			ST_CLOSE_COAST: s.obstacle_near = chance(8);
			ST_CLOSE_SLOW: begin
				s.obstacle_near = chance(8);
				s.fully_closed  = chance(4);
			end
			ST_CLOSE_REOPEN: s.aux_outer_limit = chance(3);
			default: ;
		endcase
		if (chance(50))
			s.command = chance(2) ? CMD_OPEN : CMD_CLOSE;
		return s;
	endfunction

	// Guided door cycles with a little noise. abort_permille sets how often a
	// halt or a stop command throws the sequencer back to the stop state.
	task automatic run_door_cycles(input int unsigned count, input int unsigned abort_permille);
		sample_t     s;
		int unsigned roll;
		logic [31:0] rnd;
		repeat (count) begin
			roll = $urandom_range(0, 999);
			if (roll < abort_permille) begin
				s = guided_sample();
				if (chance(2))
					s.halt_button = 1'b1;
				else
					s.command = CMD_STOP;
			end else if (roll < abort_permille + 60) begin
				rnd           = $urandom();
				s             = sample_t'(rnd[$bits(sample_t)-1:0]);
				s.halt_button = 1'b0;
				if (s.command == CMD_STOP)
					s.command = CMD_NONE;
			end else begin
				s = guided_sample();
			end
			send_sample(s);
		end
	endtask

	function automatic cfg_t random_speeds(input cfg_t c);
		logic [31:0] rnd;
		rnd                 = $urandom();
		c.main_speed_medium = rnd[7:0];
		c.main_speed_max    = rnd[15:8];
		c.main_speed_min    = rnd[23:16];
		c.main_speed_brake  = rnd[31:24];
		return c;
	endfunction

	// The first sample sees both limit sensors, so the closed state must win.
	// An all-ones sample then hits every field at its top, halt and stop
	// included, and an all-zeros sample runs the stop state with nothing set.
	task automatic test_power_up_and_extremes();
		send_sample(make_sample(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, CMD_STOP));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_NONE));
	endtask

	// Toggle with both limits opens; open and close commands are honored only
	// from stop or the matching rest state with the right limit sensor.
	task automatic test_serial_commands();
		send_sample(make_sample(1, 1, 1, 0, 0, 0, 0, 0, 1, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_STOP));
		send_sample(make_sample(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, CMD_OPEN));
		send_sample(make_sample(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 1, 0, 0, 0, 0, 0, 0, 0, CMD_OPEN));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, CMD_NONE));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_CLOSE));
		send_sample(make_sample(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, CMD_CLOSE));
	endtask

	// Closing with an obstacle in the medium and the full-speed states, a stop
	// while coasting, then a closing run that hits the closed limit early and
	// goes through the aux re-open into the closed state.
	task automatic test_closing_path();
		send_sample(make_sample(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 0, 1, 0, 1, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 0, 0, 0, 1, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 0, 0, 1, 0, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_STOP));
		send_sample(make_sample(1, 1, 0, 0, 0, 0, 0, 0, 1, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 1, 0, 0, 0, 1, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 0, 1, 0, 0, 0, 0, 1, 0, 0, CMD_NONE));
		send_sample(make_sample(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, CMD_CLOSE));
		send_sample(make_sample(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, CMD_OPEN));
		send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, CMD_STOP));
	endtask

	// Waits of a few ticks let whole open and close cycles run many times.
	task automatic test_short_waits();
		cfg_t c;
		c                     = random_speeds(CFG_RESET);
		c.magnet_release_wait = 8'($urandom_range(0, 4));
		c.opening_pause_wait  = 8'($urandom_range(0, 4));
		c.closing_coast_wait  = 8'($urandom_range(0, 4));
		c.latch_hold_wait     = 8'($urandom_range(0, 4));
		program_registers(c);
		run_door_cycles(300, 8);
	endtask

	// Every register at zero, with both sides running flat out.
	task automatic test_zero_registers();
		program_registers('0);
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		run_door_cycles(250, 8);
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	// Every register at its top: the waits can never be exceeded, so the
	// sequencer parks in the first waiting state until it is stopped.
	task automatic test_full_registers();
		program_registers('1);
		run_door_cycles(200, 15);
	endtask

	// Waits right below and at the timer cap, with aborts rare enough that
	// the timer runs into saturation.
	task automatic test_timer_saturation();
		cfg_t c;
		c                     = random_speeds(CFG_RESET);
		c.magnet_release_wait = WAIT_CAP - 8'd1;
		c.opening_pause_wait  = 8'd2;
		c.closing_coast_wait  = 8'd3;
		c.latch_hold_wait     = WAIT_CAP;
		program_registers(c);
		run_door_cycles(500, 1);
	endtask

	task automatic test_default_registers();
		program_registers(CFG_RESET);
		run_door_cycles(250, 5);
	endtask

	// Mostly short waits, now and then any value at all.
	task automatic test_random_registers();
		cfg_t c;
		c                     = random_speeds(CFG_RESET);
		c.magnet_release_wait = chance(4) ? 8'($urandom()) : 8'($urandom_range(0, 6));
		c.opening_pause_wait  = chance(4) ? 8'($urandom()) : 8'($urandom_range(0, 6));
		c.closing_coast_wait  = chance(4) ? 8'($urandom()) : 8'($urandom_range(0, 6));
		c.latch_hold_wait     = chance(4) ? 8'($urandom()) : 8'($urandom_range(0, 6));
		program_registers(c);
		run_door_cycles(300, 8);
	endtask

	// Result side pacing: mostly short runs of ready and short stalls, with an
	// occasional long stall. Changes are made at the falling edge.
	always @(negedge clk) begin : receiver_pacing
		int unsigned roll;
		if (!receiver_stalls) begin
			result_ready <= 1'b1;
			ready_hold = 0;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				result_ready <= 1'b1;
				ready_hold = $urandom_range(0, 6);
			end else if (roll < 93) begin
				result_ready <= 1'b0;
				ready_hold = $urandom_range(0, 2);
			end else begin
				result_ready <= 1'b0;
				ready_hold = $urandom_range(3, 40);
			end
		end
	end

	// Each result transfer is compared field by field with the oldest
	// prediction. Values are taken at the rising edge, before the block's own
	// registers update.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			results_checked++;
			if (door_outputs_due.size() == 0) begin
				record_failure($sformatf("result with no sample outstanding: %s",
					describe(result)));
			end else begin
				want = door_outputs_due.pop_front();
				states_seen[want.state_code] = 1'b1;
				if (result.main_drive !== want.main_drive
						|| result.main_duty !== want.main_duty
						|| result.aux_drive !== want.aux_drive
						|| result.magnet_engaged !== want.magnet_engaged
						|| result.state_code !== want.state_code) begin
					record_failure($sformatf("result %0d: expected %s, got %s",
						results_checked, describe(want), describe(result)));
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_power_up_and_extremes();
		test_serial_commands();
		test_closing_path();
		test_short_waits();
		test_zero_registers();
		test_full_registers();
		test_timer_saturation();
		test_default_registers();
		test_random_registers();

		// Let the last transfers come back, then keep the clock running so that any
		// result that should not be there still shows.
		wait_for_results();
		repeat (8) @(posedge clk);
		failures += door_outputs_due.size();

		$display("%0d samples sent and %0d results checked under %0d register settings",
			samples_sent, results_checked, settings_used);
		$display("%0d of 16 sequencer states reached, %0d failures",
			$countones(states_seen), failures);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results outstanding", door_outputs_due.size());
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
design/dds_pkg.sv
design/dds_cfg.sv
design/dds_step.sv
design/door_drive_sequencer.sv
sim/testbench.sv
